### sv/rpbg_pkg.sv
// Shared types and constants for the relay pulse burst generator.
package rpbg_pkg;

	localparam int CHANNELS     = 4;
	localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int REG_COUNT    = 2 * CHANNELS;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 8;
	localparam int TIMER_W      = 8;
	localparam int COUNT_W      = 16;
	localparam int REQ_W        = 2;
	localparam int CHAN_FIELD_W = 2;
	localparam int RELAY_W      = 4;
	localparam int SETTLE_LIMIT = 4 * CHANNELS + 8;
	localparam int BUD_W        = $clog2(SETTLE_LIMIT + 1);

	localparam logic [TIMER_W-1:0] PHASE_RESET = TIMER_W'(100);

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_START = 2'd2
	} req_type_t;

endpackage

### sv/relay_pulse_burst_generator_unit.sv
// Top level of the relay pulse burst generator: request decode, pass sequencing, result register.
//
// Each request beat (tick, load or start) is resolved in one combinational pass from the
// accepted beat and the current pass state into the next state and a result beat held in
// the result register, so one beat is taken every clock while the result side keeps up.
// The request side stays ready while the result register is empty or is being drained in
// the same cycle. A tick that ends a phase may walk through zero-length phases and empty
// channels within that same cycle. Timing registers are written on the configuration
// channel, which is always ready; indexes past the register list are ignored.
module relay_pulse_burst_generator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [rpbg_pkg::REQ_W-1:0]        req_type,
	input  logic [rpbg_pkg::CHAN_FIELD_W-1:0] channel,
	input  logic [rpbg_pkg::COUNT_W-1:0]      pulse_count,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [rpbg_pkg::RELAY_W-1:0]      relays,
	output logic                             busy_res,
	output logic                             rejected,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rpbg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rpbg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rpbg_pkg::*;

	logic [TIMER_W-1:0] on_q  [CHANNELS];
	logic [TIMER_W-1:0] off_q [CHANNELS];

	logic [COUNT_W-1:0] pend_q [CHANNELS];
	logic [CH_W-1:0]    act_q;
	logic [COUNT_W-1:0] left_q;
	logic [TIMER_W-1:0] timer_q;
	logic               high_q;
	logic               run_q;

	logic [COUNT_W-1:0] pend_d [CHANNELS];
	logic [CH_W-1:0]    act_d;
	logic [COUNT_W-1:0] left_d;
	logic [TIMER_W-1:0] timer_d;
	logic               high_d;
	logic               run_d;
	logic               rej_d;
	logic [RELAY_W-1:0] relays_d;

	logic               res_valid_q;
	logic [RELAY_W-1:0] relays_q;
	logic               busy_q;
	logic               rej_q;

	logic               req_fire;
	logic [CH_W-1:0]    cfg_ch;

	// settle scratch
	logic               do_adv;
	logic [CH_W:0]      adv_s;
	logic [BUD_W-1:0]   budget;
	logic [BUD_W-1:0]   bud0;
	logic [BUD_W-1:0]   half_up;
	logic [BUD_W-1:0]   rest;
	logic [TIMER_W-1:0] timer_dec;
	logic [TIMER_W-1:0] cur_on;
	logic [TIMER_W-1:0] cur_off;
	logic               found;
	logic [CH_W-1:0]    hit;
	logic [CH_W:0]      n_take;
	logic [CH_W:0]      m_take;
	logic [CH_W:0]      last_take;

	assign req_ready = !res_valid_q || res_ready;
	assign req_fire  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign cfg_ch    = CH_W'(cfg_index >> 1);

	assign res_valid = res_valid_q;
	assign relays    = relays_q;
	assign busy_res  = busy_q;
	assign rejected  = rej_q;

	always_comb begin
		pend_d    = pend_q;
		act_d     = act_q;
		left_d    = left_q;
		timer_d   = timer_q;
		high_d    = high_q;
		run_d     = run_q;
		rej_d     = 1'b0;
		do_adv    = 1'b0;
		adv_s     = '0;
		budget    = BUD_W'(SETTLE_LIMIT);
		bud0      = '0;
		half_up   = '0;
		rest      = '0;
		found     = 1'b0;
		hit       = '0;
		n_take    = '0;
		m_take    = '0;
		last_take = '0;
		cur_on    = on_q[act_q];
		cur_off   = off_q[act_q];
		timer_dec = (timer_q != '0) ? timer_q - 1'b1 : '0;

		case (req_type)
			REQ_TICK: begin
				if (run_q) begin
					timer_d = timer_dec;
					if (timer_dec == '0) begin
						if (cur_on == '0 && cur_off == '0) begin
							// both phases empty: two steps per pulse until the step limit
							bud0    = BUD_W'(SETTLE_LIMIT) - BUD_W'(high_q);
							half_up = (bud0 >> 1) + BUD_W'(bud0[0]);
							if (left_q <= COUNT_W'(bud0 >> 1)) begin
								budget = bud0 - {left_q[BUD_W-2:0], 1'b0};
								left_d = '0;
								high_d = 1'b0;
								do_adv = 1'b1;
								adv_s  = {1'b0, act_q} + 1'b1;
							end else begin
								left_d = left_q - COUNT_W'(half_up);
								high_d = bud0[0];
							end
						end else if (high_q && cur_off != '0) begin
							high_d  = 1'b0;
							timer_d = cur_off;
						end else if (left_q != '0) begin
							left_d = left_q - 1'b1;
							if (cur_on != '0) begin
								high_d  = 1'b1;
								timer_d = cur_on;
							end else begin
								high_d  = 1'b0;
								timer_d = cur_off;
							end
						end else begin
							high_d = 1'b0;
							do_adv = 1'b1;
							adv_s  = {1'b0, act_q} + 1'b1;
						end
					end
				end
			end
			REQ_LOAD: begin
				if (run_q) begin
					rej_d = 1'b1;
				end else if (32'(channel) < CHANNELS) begin
					pend_d[CH_W'(channel)] = pulse_count;
				end
			end
			REQ_START: begin
				if (run_q) begin
					rej_d = 1'b1;
				end else begin
					run_d   = 1'b1;
					left_d  = '0;
					high_d  = 1'b0;
					timer_d = '0;
					do_adv  = 1'b1;
					adv_s   = '0;
				end
			end
			default: begin
			end
		endcase

		if (do_adv) begin
			// first channel at or after adv_s with pulses to emit
			for (int i = CHANNELS - 1; i >= 0; i--) begin
				if ((CH_W+1)'(i) >= adv_s && pend_q[i] != '0 &&
						!(on_q[i] == '0 && off_q[i] == '0)) begin
					found = 1'b1;
					hit   = CH_W'(i);
				end
			end
			n_take = found ? ({1'b0, hit} - adv_s + 1'b1) : ((CH_W+1)'(CHANNELS) - adv_s);
			m_take = (budget < BUD_W'(n_take)) ? budget[CH_W:0] : n_take;
			for (int i = 0; i < CHANNELS; i++) begin
				if ((CH_W+1)'(i) >= adv_s && (CH_W+1)'(i) < adv_s + m_take) begin
					pend_d[i] = '0;
				end
			end
			last_take = adv_s + m_take - 1'b1;
			if (m_take != '0 && m_take < n_take) begin
				act_d   = last_take[CH_W-1:0];
				left_d  = '0;
				high_d  = 1'b0;
				timer_d = '0;
			end else if (m_take == n_take) begin
				rest = budget - BUD_W'(n_take);
				if (found) begin
					act_d = hit;
					if (rest == '0) begin
						left_d  = pend_q[hit];
						high_d  = 1'b0;
						timer_d = '0;
					end else begin
						left_d = pend_q[hit] - 1'b1;
						if (on_q[hit] != '0 || rest == BUD_W'(1)) begin
							high_d  = 1'b1;
							timer_d = on_q[hit];
						end else begin
							high_d  = 1'b0;
							timer_d = off_q[hit];
						end
					end
				end else begin
					act_d   = CH_W'(CHANNELS - 1);
					left_d  = '0;
					high_d  = 1'b0;
					timer_d = '0;
					if (rest != '0) begin
						run_d = 1'b0;
					end
				end
			end
		end

		relays_d = (run_d && high_d) ? (RELAY_W'(1) << act_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				on_q[i]  <= PHASE_RESET;
				off_q[i] <= PHASE_RESET;
			end
		end else if (cfg_valid && cfg_ready && 32'(cfg_index) < REG_COUNT) begin
			if (!cfg_index[0]) begin
				on_q[cfg_ch] <= TIMER_W'(cfg_data);
			end else begin
				off_q[cfg_ch] <= TIMER_W'(cfg_data);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pend_q[i] <= '0;
			end
			act_q   <= '0;
			left_q  <= '0;
			timer_q <= '0;
			high_q  <= 1'b0;
			run_q   <= 1'b0;
		end else if (req_fire) begin
			pend_q  <= pend_d;
			act_q   <= act_d;
			left_q  <= left_d;
			timer_q <= timer_d;
			high_q  <= high_d;
			run_q   <= run_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			relays_q <= relays_d;
			busy_q   <= run_d;
			rej_q    <= rej_d;
		end
	end

endmodule

### sv/rpbg_checker.sv
// Port-level checks for the relay pulse burst generator, bound to the top level.
module rpbg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic [rpbg_pkg::RELAY_W-1:0]      relays,
	input logic                             busy_res,
	input logic                             rejected
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(relays) && $stable(busy_res) &&
			$stable(rejected))
		else $error("result beat changed while stalled");

	a_one_relay: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0(relays))
		else $error("more than one relay driven");

	a_relay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && relays != '0 |-> busy_res)
		else $error("relay high outside a pass");

	// a rejected request never ends the pass it collided with
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rejected |-> busy_res)
		else $error("request rejected while idle");

endmodule

bind relay_pulse_burst_generator_unit rpbg_checker u_rpbg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.relays    (relays),
	.busy_res  (busy_res),
	.rejected  (rejected)
);

### tb/relay_pulse_burst_generator_unit_tb.sv
// Self-checking testbench for the relay pulse burst generator with randomized handshakes.
module relay_pulse_burst_generator_unit_tb;
	import rpbg_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int ON_SLOT     = 0;
	localparam int OFF_SLOT    = 1;
	localparam int TM_SMALL    = 0;
	localparam int TM_MAX      = 1;
	localparam int TM_ZERO     = 2;
	localparam int TM_MIXED    = 3;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 80;
	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		logic [REQ_W-1:0]        kind;
		logic [CHAN_FIELD_W-1:0] ch;
		logic [COUNT_W-1:0]      cnt;
	} burst_item_t;

	typedef struct packed {
		logic [RELAY_W-1:0] relays;
		logic               busy;
		logic               rejected;
	} relay_state_t;

	logic                    clk;
	logic                    arst_n      = 1'b0;
	logic                    req_valid   = 1'b0;
	logic                    req_ready;
	logic [REQ_W-1:0]        req_type    = '0;
	logic [CHAN_FIELD_W-1:0] channel     = '0;
	logic [COUNT_W-1:0]      pulse_count = '0;
	logic                    res_valid;
	logic                    res_ready   = 1'b0;
	logic [RELAY_W-1:0]      relays;
	logic                    busy_res;
	logic                    rejected;
	logic                    cfg_valid   = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index   = '0;
	logic [CFG_DATA_W-1:0]   cfg_data    = '0;

	// predictor state
	logic [TIMER_W-1:0] t_on [CHANNELS];
	logic [TIMER_W-1:0] t_off[CHANNELS];
	logic [COUNT_W-1:0] pend_cnt[CHANNELS];
	logic [CH_W-1:0]    act_ch;
	logic [COUNT_W-1:0] pulses_rem;
	logic [TIMER_W-1:0] phase_left;
	bit                 high_phase;
	bit                 pass_on;

	burst_item_t  beat_q[$];
	relay_state_t expected_levels_q[$];
	burst_item_t  cur_item = '0;
	bit           req_busy  = 1'b0;
	bit           req_taken = 1'b0;
	int           send_gap  = 0;
	int           stall_left = 0;
	int           hold_left = 0;
	int           hold_ask  = 0;
	bit           calm      = 1'b0;
	int           quiet_cycles = 0;
	int           errors    = 0;
	int           queued_total = 0;

	relay_pulse_burst_generator_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.channel    (channel),
		.pulse_count(pulse_count),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.relays     (relays),
		.busy_res   (busy_res),
		.rejected   (rejected),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void claim_channel(input logic [CH_W-1:0] c);
		act_ch = c;
		pulses_rem = pend_cnt[c];
		pend_cnt[c] = '0;
		if (t_on[c] == 0 && t_off[c] == 0)
			pulses_rem = '0;
		high_phase = 1'b0;
		phase_left = '0;
	endfunction

	// walk through zero-length phases and empty channels
	function automatic void skip_empty_phases();
		int g;
		for (g = 0; g < SETTLE_LIMIT && pass_on; g++) begin
			if (phase_left != 0)
				return;
			if (high_phase) begin
				high_phase = 1'b0;
				phase_left = t_off[act_ch];
			end else if (pulses_rem != 0) begin
				pulses_rem = pulses_rem - 1'b1;
				high_phase = 1'b1;
				phase_left = t_on[act_ch];
			end else if (int'(act_ch) < CHANNELS - 1) begin
				claim_channel(act_ch + 1'b1);
			end else begin
				pass_on = 1'b0;
				high_phase = 1'b0;
			end
		end
	endfunction

	function automatic relay_state_t predict_relays(input burst_item_t it);
		relay_state_t r;
		r = '0;
		case (it.kind)
			REQ_TICK: begin
				if (pass_on) begin
					if (phase_left != 0)
						phase_left = phase_left - 1'b1;
					skip_empty_phases();
				end
			end
			REQ_LOAD: begin
				if (pass_on)
					r.rejected = 1'b1;
				else
					pend_cnt[it.ch] = it.cnt;
			end
			REQ_START: begin
				if (pass_on) begin
					r.rejected = 1'b1;
				end else begin
					pass_on = 1'b1;
					claim_channel('0);
					skip_empty_phases();
				end
			end
			default: ;
		endcase
		if (pass_on && high_phase)
			r.relays = RELAY_W'(1) << act_ch;
		r.busy = pass_on;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken) begin
				req_taken = 1'b0;
				req_busy = 1'b0;
			end
			if (!req_busy) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (beat_q.size() != 0) begin
					cur_item = beat_q.pop_front();
					req_busy = 1'b1;
					send_gap = pick_gap();
				end
			end
			req_valid <= req_busy;
			req_type <= cur_item.kind;
			channel <= cur_item.ch;
			pulse_count <= cur_item.cnt;
		end
	end

	always @(negedge clk) begin
		if (hold_ask != 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else begin
			stall_left = pick_gap();
			res_ready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		relay_state_t got;
		relay_state_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (res_valid && res_ready) begin
				quiet_cycles = 0;
				got = {relays, busy_res, rejected};
				if (expected_levels_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: relays=%h busy=%b rej=%b",
						$time, got.relays, got.busy, got.rejected);
				end else begin
					want = expected_levels_q.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch: expected relays=%h busy=%b rej=%b, got relays=%h busy=%b rej=%b",
							$time, want.relays, want.busy, want.rejected,
							got.relays, got.busy, got.rejected);
					end
				end
			end
			if (req_valid && req_ready) begin
				quiet_cycles = 0;
				expected_levels_q.push_back(predict_relays({req_type, channel, pulse_count}));
				req_taken = 1'b1;
			end
			if (cfg_valid && cfg_ready)
				quiet_cycles = 0;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic queue_item(input logic [REQ_W-1:0] kind, input int ch, input int cnt);
		beat_q.push_back('{kind: kind, ch: CHAN_FIELD_W'(ch), cnt: COUNT_W'(cnt)});
		queued_total++;
	endtask

	task automatic wait_idle();
		while (beat_q.size() != 0 || req_valid || expected_levels_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic finish_pass();
		wait_idle();
		while (pass_on) begin
			repeat (16) queue_item(REQ_TICK, $urandom, $urandom);
			wait_idle();
		end
	endtask

	task automatic cfg_write(input int idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < REG_COUNT) begin
			if (idx % 2 == ON_SLOT)
				t_on[idx / 2] = val;
			else
				t_off[idx / 2] = val;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [TIMER_W-1:0] pick_time(input int mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			TM_MAX:   return (r < 25) ? 8'd255 : 8'd0;
			TM_ZERO:  return 8'd0;
			TM_MIXED: return (r < 40) ? 8'd0 : (r < 85) ? 8'd1 : 8'd255;
			default:  return (r < 25) ? 8'd0 : (r < 90) ? TIMER_W'($urandom_range(1, 4)) :
				TIMER_W'($urandom_range(5, 9));
		endcase
	endfunction

	task automatic set_timing(input int mode);
		int c;
		for (c = 0; c < CHANNELS; c++) begin
			cfg_write(2 * c + ON_SLOT, pick_time(mode));
			cfg_write(2 * c + OFF_SLOT, pick_time(mode));
		end
		// index past the register list must be ignored
		cfg_write($urandom_range(REG_COUNT, 2 ** CFG_IDX_W - 1), CFG_DATA_W'($urandom));
	endtask

	// a channel with both times zero burns its count at once, so any count is safe there
	function automatic logic [COUNT_W-1:0] load_count(input int c, input int cnt_hi);
		if (t_on[c] == 0 && t_off[c] == 0)
			return COUNT_W'($urandom);
		return COUNT_W'($urandom_range(0, cnt_hi));
	endfunction

	task automatic queue_burst(input int cnt_hi);
		int c;
		int k;
		int n_ticks;
		for (c = 0; c < CHANNELS; c++) begin
			if ($urandom_range(0, 9) == 0)
				queue_item(REQ_LOAD, c, $urandom);
			queue_item(REQ_LOAD, c, load_count(c, cnt_hi));
		end
		queue_item(REQ_START, $urandom, $urandom);
		n_ticks = $urandom_range(0, 40);
		for (k = 0; k < n_ticks; k++) begin
			c = $urandom_range(0, CHANNELS - 1);
			case ($urandom_range(0, 19))
				0:       queue_item(REQ_LOAD, c, load_count(c, cnt_hi));
				1:       queue_item(REQ_START, $urandom, $urandom);
				2:       queue_item(REQ_UNUSED, $urandom, $urandom);
				default: queue_item(REQ_TICK, $urandom, $urandom);
			endcase
		end
	endtask

	initial begin
		int i;
		int p;
		int first;
		int modes[PHASES];
		modes = '{TM_SMALL, TM_SMALL, TM_MAX, TM_ZERO, TM_MIXED, TM_SMALL, TM_SMALL, TM_MIXED};
		for (i = 0; i < CHANNELS; i++) begin
			t_on[i] = PHASE_RESET;
			t_off[i] = PHASE_RESET;
			pend_cnt[i] = '0;
		end
		act_ch = '0;
		pulses_rem = '0;
		phase_left = '0;
		high_phase = 1'b0;
		pass_on = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset timing, idle corner cases, one pulse on channel 2
		queue_item(REQ_TICK, 2'd3, 16'hFFFF);
		queue_item(REQ_UNUSED, 2'd0, 16'h0000);
		queue_item(REQ_START, 2'd0, 16'h0000);
		queue_item(REQ_LOAD, 2'd0, 16'hFFFF);
		queue_item(REQ_LOAD, 2'd0, 16'h0000);
		queue_item(REQ_LOAD, 2'd2, 16'd1);
		queue_item(REQ_START, 2'd1, 16'h5555);
		queue_item(REQ_LOAD, 2'd3, 16'hFFFF);
		queue_item(REQ_START, 2'd2, 16'hAAAA);
		queue_item(REQ_UNUSED, 2'd3, 16'hFFFF);
		finish_pass();

		// zero-length high phase, both times zero, zero count on the last channel
		cfg_write(0 * 2 + ON_SLOT, 8'd1);
		cfg_write(0 * 2 + OFF_SLOT, 8'd0);
		cfg_write(1 * 2 + ON_SLOT, 8'd0);
		cfg_write(1 * 2 + OFF_SLOT, 8'd0);
		cfg_write(2 * 2 + ON_SLOT, 8'd0);
		cfg_write(2 * 2 + OFF_SLOT, 8'd2);
		cfg_write(3 * 2 + ON_SLOT, 8'd3);
		cfg_write(3 * 2 + OFF_SLOT, 8'd1);
		queue_item(REQ_LOAD, 2'd0, 16'd2);
		queue_item(REQ_LOAD, 2'd1, 16'hFFFF);
		queue_item(REQ_LOAD, 2'd2, 16'd1);
		queue_item(REQ_LOAD, 2'd3, 16'd0);
		queue_item(REQ_START, 2'd0, 16'd0);
		repeat (8) queue_item(REQ_TICK, 2'd0, 16'd0);
		finish_pass();

		for (p = 0; p < PHASES; p++) begin
			calm = (p == 2 || p == 5);
			set_timing(modes[p]);
			first = queued_total;
			while (queued_total - first < PHASE_ITEMS)
				queue_burst((modes[p] == TM_SMALL) ? 3 : 1);
			if (p == 1)
				hold_ask = 80;
			finish_pass();
		end

		calm = 1'b0;
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
